>>> sv/buzzer_melody_sequencer_unit_macros.svh
// assertion macros for the melody sequencer unit
// used by the top level only, no other dependencies
`ifndef BUZZER_MELODY_SEQUENCER_UNIT_MACROS_SVH
`define BUZZER_MELODY_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define BMSU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define BMSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BMSU_ASSERT_SAME(lbl, ante, cons)
`define BMSU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> sv/bms_pkg.sv
// types, codes and the fixed note table of the melody sequencer
// no dependencies; imported by bms_seq and the top level
package bms_pkg;

  // request codes
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_NONE  = 2'd3
  } bms_req_e_t;

  // melody selection codes
  localparam logic [2:0] SEL_RANDOM   = 3'd4;
  localparam logic [1:0] MEL_RAND_LO  = 2'd0;
  localparam logic [1:0] MEL_RAND_HI  = 2'd2;
  localparam logic [1:0] MEL_NOISY    = 2'd2;

  // configuration register map
  localparam int unsigned CFG_ADDR_W       = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_NOISY_NOTE_MS = 3'd0;
  localparam logic [7:0]  NOISY_NOTE_MS_RST = 8'd10;

  // one input transaction
  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] melody_sel;
    logic       random_bit;
  } bms_item_t;

  // one result transaction
  typedef struct packed {
    logic        note_start;
    logic [11:0] note_freq;
    logic [7:0]  note_ms;
    logic        note_is_sweep;
    logic        silence;
    logic        playing;
    logic        finished;
  } bms_res_t;

  // note frequency in Hz
  function automatic logic [11:0] tbl_freq(input logic [1:0] mel, input logic [1:0] idx);
    logic [11:0] f;
    f = 12'd0;
    case (mel)
      2'd0: case (idx)
        2'd0: f = 12'd880;
        2'd1: f = 12'd1109;
        2'd2: f = 12'd1319;
        default: f = 12'd0;
      endcase
      2'd1: case (idx)
        2'd0: f = 12'd1319;
        2'd1: f = 12'd1109;
        2'd2: f = 12'd880;
        default: f = 12'd0;
      endcase
      2'd2: case (idx)
        2'd0: f = 12'd1500;
        2'd1: f = 12'd2500;
        default: f = 12'd0;
      endcase
      default: case (idx)
        2'd0: f = 12'd880;
        2'd1: f = 12'd1760;
        2'd2: f = 12'd1319;
        default: f = 12'd0;
      endcase
    endcase
    return f;
  endfunction

  // table note duration in ms, zero for the noisy melody
  function automatic logic [7:0] tbl_dur(input logic [1:0] mel, input logic [1:0] idx);
    logic [7:0] d;
    d = 8'd0;
    if (mel != MEL_NOISY && idx != 2'd3) begin
      d = 8'd30;
    end
    return d;
  endfunction

  // silence before each note in ms
  function automatic logic [7:0] tbl_gap(input logic [1:0] mel, input logic [1:0] idx);
    logic [7:0] g;
    g = 8'd0;
    if (mel == MEL_NOISY) begin
      if (idx == 2'd0 || idx == 2'd1) begin
        g = 8'd50;
      end
    end else begin
      case (idx)
        2'd0: g = 8'd150;
        2'd1: g = 8'd30;
        2'd2: g = 8'd30;
        default: g = 8'd0;
      endcase
    end
    return g;
  endfunction

  // number of notes in a melody
  function automatic logic [1:0] tbl_len(input logic [1:0] mel);
    return (mel == MEL_NOISY) ? 2'd2 : 2'd3;
  endfunction

endpackage

>>> sv/bms_seq.sv
// melody sequencer state and single-pass step logic
// depends on bms_pkg; holds active, melody, note, elapsed and issued state
module bms_seq import bms_pkg::*; #(
  parameter int unsigned ELAPSED_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  bms_item_t item,
  input  logic [7:0] noisy_note_ms,
  output bms_res_t  res
);

  logic                     active_r, active_nxt;
  logic [1:0]               melody_r, melody_nxt;
  logic [1:0]               note_r, note_nxt;
  logic [ELAPSED_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic                     issued_r, issued_nxt;

  logic [1:0]               ni;
  logic [1:0]               mel_len;
  logic                     noisy;
  logic [7:0]               gap;
  logic [7:0]               dur;
  logic [7:0]               len_ms;
  logic [8:0]               end_ms;
  logic [ELAPSED_WIDTH-1:0] elapsed_inc;
  logic [2:0]               ni_next;
  bms_req_e_t               req;

  // current note lookup
  always_comb begin
    mel_len     = tbl_len(melody_r);
    noisy       = (melody_r == MEL_NOISY);
    ni          = (note_r >= mel_len) ? 2'd0 : note_r;
    gap         = tbl_gap(melody_r, ni);
    dur         = tbl_dur(melody_r, ni);
    len_ms      = noisy ? noisy_note_ms : dur;
    end_ms      = {1'b0, gap} + {1'b0, len_ms};
    elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
    ni_next     = {1'b0, ni} + 3'd1;
    req         = bms_req_e_t'(item.req_type);
  end

  // next state and result
  always_comb begin
    active_nxt  = active_r;
    melody_nxt  = melody_r;
    note_nxt    = note_r;
    elapsed_nxt = elapsed_r;
    issued_nxt  = issued_r;
    res         = '0;
    unique case (req)
      REQ_START: begin
        if (!active_r && item.melody_sel <= SEL_RANDOM) begin
          if (item.melody_sel == SEL_RANDOM) begin
            melody_nxt = item.random_bit ? MEL_RAND_HI : MEL_RAND_LO;
          end else begin
            melody_nxt = item.melody_sel[1:0];
          end
          note_nxt    = 2'd0;
          elapsed_nxt = '0;
          issued_nxt  = 1'b0;
          active_nxt  = 1'b1;
        end
      end
      REQ_STOP: begin
        res.silence = 1'b1;
        active_nxt  = 1'b0;
        issued_nxt  = 1'b0;
      end
      REQ_TICK: begin
        if (active_r) begin
          elapsed_nxt = elapsed_inc;
          // note begins once the gap has passed
          if (elapsed_inc >= ELAPSED_WIDTH'(gap) && !issued_r) begin
            res.note_start    = 1'b1;
            res.note_freq     = tbl_freq(melody_r, ni);
            res.note_ms       = dur;
            res.note_is_sweep = noisy;
            issued_nxt        = 1'b1;
          end
          // gap plus length passed: next note or end of melody
          if (elapsed_inc >= ELAPSED_WIDTH'(end_ms)) begin
            if (ni_next >= {1'b0, mel_len}) begin
              active_nxt   = 1'b0;
              res.finished = 1'b1;
              note_nxt     = 2'd0;
            end else begin
              note_nxt = ni_next[1:0];
            end
            elapsed_nxt = '0;
            issued_nxt  = 1'b0;
          end
        end
      end
      REQ_NONE: begin
      end
      default: begin
      end
    endcase
    res.playing = active_nxt;
  end

  // state registers, updated once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      melody_r  <= 2'd0;
      note_r    <= 2'd0;
      elapsed_r <= '0;
      issued_r  <= 1'b0;
    end else if (step) begin
      active_r  <= active_nxt;
      melody_r  <= melody_nxt;
      note_r    <= note_nxt;
      elapsed_r <= elapsed_nxt;
      issued_r  <= issued_nxt;
    end
  end

endmodule

>>> sv/buzzer_melody_sequencer_unit.sv
// top level of the melody sequencer: channels, config register, pipeline
// depends on bms_pkg, bms_seq and buzzer_melody_sequencer_unit_macros.svh
//
// Usage: each input transaction is a one-millisecond tick, a start request
// (melody 0..3, or 4 for a random pick of melody 0 or 2) or a stop. Every
// input transaction gives exactly one result transaction with the note-start
// command, its frequency, table length and sweep flag, and the silence,
// playing and finished flags.
// Pipeline: a transaction accepted into the input register is stepped
// through the melody state once the result register is free and is shown
// on the out_ channel from the result register. Throughput: one transaction
// per cycle while out_stall is low; the input register feeds the result
// register through one pass of table lookup, increment and compare.
// Stall: while out_stall holds a result, the input register keeps the next
// transaction and in_stall rises once that register is full.
// Reset: melody idle, elapsed counter zero, noisy_note_ms back to 10, both
// channels empty. The register sits at byte address 0 of the APB port.
`include "buzzer_melody_sequencer_unit_macros.svh"
module buzzer_melody_sequencer_unit import bms_pkg::*; #(
  parameter int unsigned ELAPSED_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_req_type,
  input  logic [2:0]            in_melody_sel,
  input  logic                  in_random_bit,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_note_start,
  output logic [11:0]           out_note_freq,
  output logic [7:0]            out_note_ms,
  output logic                  out_note_is_sweep,
  output logic                  out_silence,
  output logic                  out_playing,
  output logic                  out_finished,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic       noisy_ms_hit;
  logic [7:0] noisy_note_ms_r;
  logic       in_valid_r;
  bms_item_t  in_item_r;
  logic       out_valid_r;
  bms_res_t   out_res_r;
  bms_res_t   step_res;
  logic       in_take;
  logic       out_free;
  logic       step;

  // configuration port
  assign pready = 1'b1;
  assign noisy_ms_hit = (paddr == ADDR_NOISY_NOTE_MS);
  assign prdata = noisy_ms_hit ? {24'd0, noisy_note_ms_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noisy_note_ms_r <= NOISY_NOTE_MS_RST;
    end else if (psel && penable && pwrite && noisy_ms_hit) begin
      noisy_note_ms_r <= pwdata[7:0];
    end
  end

  // handshake control
  assign out_free = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= '{req_type: in_req_type, melody_sel: in_melody_sel,
                     random_bit: in_random_bit};
    end
  end

  // melody state and step logic
  bms_seq #(
    .ELAPSED_WIDTH (ELAPSED_WIDTH)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .item          (in_item_r),
    .noisy_note_ms (noisy_note_ms_r),
    .res           (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_note_start    = out_res_r.note_start;
  assign out_note_freq     = out_res_r.note_freq;
  assign out_note_ms       = out_res_r.note_ms;
  assign out_note_is_sweep = out_res_r.note_is_sweep;
  assign out_silence       = out_res_r.silence;
  assign out_playing       = out_res_r.playing;
  assign out_finished      = out_res_r.finished;

  // checks
  `BMSU_ASSERT_SAME(a_stop_quiet, out_valid_r && out_res_r.silence,
    !out_res_r.playing && !out_res_r.note_start && !out_res_r.finished)
  `BMSU_ASSERT_SAME(a_finish_idle, out_valid_r && out_res_r.finished, !out_res_r.playing)
  `BMSU_ASSERT_SAME(a_no_note_zero, out_valid_r && !out_res_r.note_start,
    out_res_r.note_freq == 12'd0 && out_res_r.note_ms == 8'd0 && !out_res_r.note_is_sweep)
  `BMSU_ASSERT_NEXT(a_step_shows, step, out_valid_r)

endmodule

>>> tb/buzzer_melody_sequencer_unit_tb.sv
// self-checking testbench for the melody sequencer unit
// depends on bms_pkg and buzzer_melody_sequencer_unit; predicts each result in place
// directed idle, ignored and start cases, then random melodies over several note lengths
module buzzer_melody_sequencer_unit_tb import bms_pkg::*;;

  localparam int unsigned ELAPSED_W = 16;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_req_type;
  logic [2:0]            in_melody_sel;
  logic                  in_random_bit;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_note_start;
  logic [11:0]           out_note_freq;
  logic [7:0]            out_note_ms;
  logic                  out_note_is_sweep;
  logic                  out_silence;
  logic                  out_playing;
  logic                  out_finished;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  buzzer_melody_sequencer_unit #(.ELAPSED_WIDTH(ELAPSED_W)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_melody_sel(in_melody_sel), .in_random_bit(in_random_bit),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_note_start(out_note_start), .out_note_freq(out_note_freq), .out_note_ms(out_note_ms),
    .out_note_is_sweep(out_note_is_sweep), .out_silence(out_silence),
    .out_playing(out_playing), .out_finished(out_finished),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predicted melody state and register copy
  logic                 seq_active;
  logic [1:0]           seq_melody;
  logic [1:0]           seq_note;
  logic [ELAPSED_W-1:0] seq_elapsed;
  logic                 seq_issued;
  logic [7:0]           noisy_len_setting;
  logic                 item_changed_state;

  bms_res_t pending_melody_results[$];
  bms_res_t head_res;

  // run control and statistics
  bit          sender_no_gap;
  bit          receiver_no_stall;
  int unsigned hold_off_len;
  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned effective_items;
  int unsigned results_checked;
  int unsigned notes_started;
  int unsigned melodies_finished;
  int unsigned stops_seen;
  int unsigned input_held_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

  // gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // note table: tone in Hz, table length and leading silence in ms
  function automatic void note_entry(input logic [1:0] mel, input logic [1:0] idx,
                                     output logic [11:0] hz, output logic [7:0] dur,
                                     output logic [7:0] lead);
    hz = 12'd0;
    dur = 8'd0;
    lead = 8'd0;
    case ({mel, idx})
      4'b00_00: begin hz = 12'd880;  dur = 8'd30; lead = 8'd150; end
      4'b00_01: begin hz = 12'd1109; dur = 8'd30; lead = 8'd30;  end
      4'b00_10: begin hz = 12'd1319; dur = 8'd30; lead = 8'd30;  end
      4'b01_00: begin hz = 12'd1319; dur = 8'd30; lead = 8'd150; end
      4'b01_01: begin hz = 12'd1109; dur = 8'd30; lead = 8'd30;  end
      4'b01_10: begin hz = 12'd880;  dur = 8'd30; lead = 8'd30;  end
      4'b10_00: begin hz = 12'd1500; lead = 8'd50; end
      4'b10_01: begin hz = 12'd2500; lead = 8'd50; end
      4'b11_00: begin hz = 12'd880;  dur = 8'd30; lead = 8'd150; end
      4'b11_01: begin hz = 12'd1760; dur = 8'd30; lead = 8'd30;  end
      4'b11_10: begin hz = 12'd1319; dur = 8'd30; lead = 8'd30;  end
      default: ;
    endcase
  endfunction

  // advance the predicted sequencer by one transaction and return its result
  function automatic bms_res_t predict_melody_step(input bms_item_t item);
    bms_res_t    r;
    logic [11:0] hz;
    logic [7:0]  dur;
    logic [7:0]  lead;
    logic [1:0]  idx;
    int unsigned notes;
    int unsigned hold_ms;
    r = '0;
    item_changed_state = 1'b1;
    case (item.req_type)
      REQ_START: begin
        if (!seq_active && item.melody_sel <= SEL_RANDOM) begin
          if (item.melody_sel == SEL_RANDOM) begin
            seq_melody = item.random_bit ? MEL_RAND_HI : MEL_RAND_LO;
          end else begin
            seq_melody = item.melody_sel[1:0];
          end
          seq_note = 2'd0;
          seq_elapsed = '0;
          seq_issued = 1'b0;
          seq_active = 1'b1;
        end else begin
          item_changed_state = 1'b0;
        end
      end
      REQ_STOP: begin
        r.silence = 1'b1;
        seq_active = 1'b0;
        seq_issued = 1'b0;
      end
      REQ_TICK: begin
        if (seq_active) begin
          notes = (seq_melody == MEL_NOISY) ? 2 : 3;
          idx = (seq_note >= notes) ? 2'd0 : seq_note;
          note_entry(seq_melody, idx, hz, dur, lead);
          hold_ms = (seq_melody == MEL_NOISY) ? noisy_len_setting : dur;
          // count first, then compare
          if (seq_elapsed != '1) seq_elapsed = seq_elapsed + 1'b1;
          if (seq_elapsed >= lead && !seq_issued) begin
            r.note_start = 1'b1;
            r.note_freq = hz;
            r.note_ms = dur;
            r.note_is_sweep = (seq_melody == MEL_NOISY);
            seq_issued = 1'b1;
          end
          if (seq_elapsed >= lead + hold_ms) begin
            if (idx + 1 >= notes) begin
              seq_active = 1'b0;
              r.finished = 1'b1;
              seq_note = 2'd0;
            end else begin
              seq_note = idx + 2'd1;
            end
            seq_elapsed = '0;
            seq_issued = 1'b0;
          end
        end else begin
          item_changed_state = 1'b0;
        end
      end
      default: item_changed_state = 1'b0;
    endcase
    r.playing = seq_active;
    return r;
  endfunction

  // one line per mismatch, printing capped
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $time);
    end
  endtask

  // result checker: compares each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) input_held_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (pending_melody_results.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 0);
      end else begin
        head_res = pending_melody_results.pop_front();
        if (out_note_start !== head_res.note_start)
          report_mismatch("note_start", out_note_start, head_res.note_start);
        if (out_note_freq !== head_res.note_freq)
          report_mismatch("note_freq", out_note_freq, head_res.note_freq);
        if (out_note_ms !== head_res.note_ms)
          report_mismatch("note_ms", out_note_ms, head_res.note_ms);
        if (out_note_is_sweep !== head_res.note_is_sweep)
          report_mismatch("note_is_sweep", out_note_is_sweep, head_res.note_is_sweep);
        if (out_silence !== head_res.silence)
          report_mismatch("silence", out_silence, head_res.silence);
        if (out_playing !== head_res.playing)
          report_mismatch("playing", out_playing, head_res.playing);
        if (out_finished !== head_res.finished)
          report_mismatch("finished", out_finished, head_res.finished);
        if (head_res.note_start) notes_started++;
        if (head_res.finished) melodies_finished++;
        if (head_res.silence) stops_seen++;
      end
    end
  end

  // result side stall: random bursts, or one long hold-off on request
  initial begin : out_stall_gen
    int unsigned stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_len != 0) begin
        out_stall <= 1'b1;
        repeat (hold_off_len) @(posedge clk);
        hold_off_len = 0;
        out_stall <= 1'b0;
      end else if (receiver_no_stall) begin
        out_stall <= 1'b0;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(3) == 0) stall_left = pick_gap();
      end
    end
  end

  // send one transaction and record its prediction at acceptance
  task automatic send_item(input logic [1:0] req, input logic [2:0] sel, input logic rbit);
    bms_item_t   item;
    int unsigned gap;
    item.req_type = req;
    item.melody_sel = sel;
    item.random_bit = rbit;
    gap = sender_no_gap ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_melody_sel <= sel;
    in_random_bit <= rbit;
    do @(posedge clk); while (in_stall);
    pending_melody_results.push_back(predict_melody_step(item));
    items_sent++;
    if (item_changed_state) effective_items++;
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_melody_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // register write, setup then access
  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // register read, returns data of the access cycle
  task automatic apb_read(input logic [CFG_ADDR_W-1:0] addr, output logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // change the noisy note length while idle and read it back
  task automatic set_noisy_len(input logic [7:0] len_ms);
    logic [31:0] rd;
    wait_for_drain();
    apb_write(ADDR_NOISY_NOTE_MS, {24'd0, len_ms});
    noisy_len_setting = len_ms;
    // the bus goes idle between write and read
    @(posedge clk);
    apb_read(ADDR_NOISY_NOTE_MS, rd);
    if (rd[7:0] !== len_ms) report_mismatch("noisy_note_ms readback", rd[7:0], len_ms);
  endtask

  // start a melody and tick it, to the end or for a number of ticks
  task automatic play_melody(input logic [2:0] sel, input logic rbit, input int unsigned cut);
    int unsigned n;
    n = 0;
    send_item(REQ_START, sel, rbit);
    while (seq_active && (cut == 0 || n < cut)) begin
      // occasional start or unused code in the middle of a melody
      if ($urandom_range(99) < 3) begin
        send_item($urandom_range(1) ? REQ_START : REQ_NONE,
                  3'($urandom_range(7)), 1'($urandom_range(1)));
      end
      send_item(REQ_TICK, 3'($urandom_range(7)), 1'($urandom_range(1)));
      n++;
    end
  endtask

  // reset value readback
  task automatic test_register_reset();
    logic [31:0] rd;
    apb_read(ADDR_NOISY_NOTE_MS, rd);
    if (rd[7:0] !== NOISY_NOTE_MS_RST)
      report_mismatch("noisy_note_ms after reset", rd[7:0], NOISY_NOTE_MS_RST);
  endtask

  // idle requests, ignored starts, random pick, stops and every melody start
  task automatic test_directed_requests();
    logic [2:0] sel;
    send_item(REQ_TICK, 3'd0, 1'b0);
    send_item(REQ_STOP, 3'd0, 1'b0);
    send_item(REQ_NONE, 3'd7, 1'b1);
    for (sel = SEL_RANDOM + 3'd1; sel != 3'd0; sel++) send_item(REQ_START, sel, sel[0]);
    send_item(REQ_START, SEL_RANDOM, 1'b1);
    send_item(REQ_START, 3'd1, 1'b0);
    send_item(REQ_TICK, 3'd3, 1'b1);
    send_item(REQ_NONE, 3'd0, 1'b0);
    send_item(REQ_STOP, 3'd4, 1'b1);
    send_item(REQ_START, SEL_RANDOM, 1'b0);
    send_item(REQ_TICK, 3'd0, 1'b0);
    send_item(REQ_STOP, 3'd0, 1'b0);
    for (int m = 0; m < 4; m++) begin
      send_item(REQ_START, m[2:0], 1'b0);
      send_item(REQ_TICK, 3'd6, 1'b1);
      send_item(REQ_STOP, 3'd2, 1'b0);
    end
  endtask

  // random melodies at one note length; quiet runs without any idling
  task automatic test_random_melodies(input logic [7:0] len_ms, input int unsigned budget,
                                      input bit quiet);
    int unsigned first;
    int unsigned pick;
    set_noisy_len(len_ms);
    sender_no_gap = quiet;
    receiver_no_stall = quiet;
    first = effective_items;
    play_melody(3'd2, 1'b0, 0);
    while (effective_items - first < budget) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        play_melody(3'($urandom_range(SEL_RANDOM)), 1'($urandom_range(1)), 0);
      end else if (pick < 80) begin
        play_melody(3'($urandom_range(SEL_RANDOM)), 1'($urandom_range(1)),
                    $urandom_range(320, 1));
        send_item(REQ_STOP, 3'($urandom_range(7)), 1'($urandom_range(1)));
      end else if (pick < 88) begin
        // left running, the next start gets ignored
        play_melody(3'($urandom_range(SEL_RANDOM)), 1'($urandom_range(1)),
                    $urandom_range(200, 1));
      end else begin
        send_item(2'($urandom_range(3)), 3'($urandom_range(7)), 1'($urandom_range(1)));
      end
    end
    sender_no_gap = 1'b0;
    receiver_no_stall = 1'b0;
  endtask

  // long result hold-off while the sender keeps offering
  task automatic test_output_hold_off();
    hold_off_len = 150;
    sender_no_gap = 1'b1;
    play_melody(3'd3, 1'b0, 60);
    send_item(REQ_STOP, 3'd0, 1'b0);
    sender_no_gap = 1'b0;
  endtask

  // sender pauses mid melody until every result is back, then resumes
  task automatic test_pause_mid_melody();
    play_melody(3'd2, 1'b0, 55);
    wait_for_drain();
    while (seq_active) send_item(REQ_TICK, 3'($urandom_range(7)), 1'($urandom_range(1)));
  endtask

  // main sequence
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_TICK;
    in_melody_sel = 3'd0;
    in_random_bit = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_NOISY_NOTE_MS;
    pwdata = 32'd0;
    seq_active = 1'b0;
    seq_melody = 2'd0;
    seq_note = 2'd0;
    seq_elapsed = '0;
    seq_issued = 1'b0;
    noisy_len_setting = NOISY_NOTE_MS_RST;
    sender_no_gap = 1'b0;
    receiver_no_stall = 1'b0;
    hold_off_len = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_reset();
    test_directed_requests();
    test_random_melodies(NOISY_NOTE_MS_RST, 150, 1'b0);
    test_pause_mid_melody();
    test_output_hold_off();
    test_random_melodies(8'd0, 50, 1'b0);
    test_random_melodies(8'd255, 50, 1'b0);
    test_random_melodies(8'($urandom_range(40, 2)), 50, 1'b0);
    test_random_melodies(8'd1, 50, 1'b1);

    wait_for_drain();
    repeat (4) @(posedge clk);
    if (pending_melody_results.size() != 0)
      report_mismatch("results never delivered", 0, pending_melody_results.size());
    $display("run: %0d transactions sent, %0d moved the melody state, %0d results checked",
             items_sent, effective_items, results_checked);
    $display("run: %0d notes, %0d melodies finished, %0d stops, %0d input stall cycles",
             notes_started, melodies_finished, stops_seen, input_held_cycles);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> buzzer_melody_sequencer_unit.f
+incdir+sv
sv/bms_pkg.sv
sv/bms_seq.sv
sv/buzzer_melody_sequencer_unit.sv
tb/buzzer_melody_sequencer_unit_tb.sv
